FILE: rtl/txf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txf_pkg: shared types and constants of the track tail crossfader
// Widths of the tail store, gain format, stream packing and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package txf_pkg;

    // tail store geometry
    localparam int TAIL_DEPTH  = 1048576;
    localparam int ADDR_W      = $clog2(TAIL_DEPTH);
    localparam int FILL_W      = ADDR_W + 1;

    // sample and gain formats
    localparam int SAMPLE_BITS = 24;
    localparam int GAIN_W      = 17;
    localparam int GAIN_FRAC   = 16;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC);
    localparam int PROD_W      = SAMPLE_BITS + GAIN_W + 1;
    localparam int ACC_W       = PROD_W + 1;
    localparam int QUOT_W      = ACC_W - GAIN_FRAC;

    // time fields
    localparam int MS_W        = 32;
    localparam int OVL_W       = 16;
    localparam int OVG_W       = OVL_W + 1;
    localparam int REM_W       = MS_W + 1;
    localparam logic [OVL_W-1:0] OVERLAP_RESET = OVL_W'(6000);
    localparam logic [OVG_W-1:0] GUARD_MS      = OVG_W'(2000);

    // divider step count: one quotient bit per step
    localparam int DIV_STEPS   = GAIN_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int DIV_REM_W   = FILL_W + 1;

    // input tdata layout, lowest bits first
    localparam int IN_SAMPLE_LO  = 0;
    localparam int IN_DUR_LO     = IN_SAMPLE_LO + SAMPLE_BITS;
    localparam int IN_EL_LO      = IN_DUR_LO + MS_W;
    localparam int IN_ACC_BIT    = IN_EL_LO + MS_W;
    localparam int IN_RATE_BIT   = IN_ACC_BIT + 1;
    localparam int IN_DIFF_BIT   = IN_RATE_BIT + 1;
    localparam int IN_USED_W     = IN_DIFF_BIT + 1;
    localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic div_start;
        logic absorb;
        logic consume;
        logic mul_a;
        logic mul_b;
        logic sum;
        logic sat;
        logic pass;
        logic load_out;
        logic req;
    } txf_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic blk_start;
        logic near_end;
        logic absorb_ok;
        logic next_acc;
        logic skip_next;
        logic fill_nz;
        logic fill_full;
        logic div_busy;
        logic out_free;
    } txf_stat_t;

endpackage
`default_nettype wire

FILE: rtl/txf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txf_div: block gain divider
// Restoring divider, one quotient bit per cycle: gain = fill * 2^16 / peak,
// held in gain_reg until the next division.
// ----------------------------------------------------------------------------
module txf_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [txf_pkg::FILL_W-1:0]    num,
    input  wire logic [txf_pkg::FILL_W-1:0]    den,
    output logic                               busy,
    output logic [txf_pkg::GAIN_W-1:0]         gain
);

    logic                              busy_reg;
    logic [txf_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [txf_pkg::DIV_REM_W-1:0]     rem_reg;
    logic [txf_pkg::DIV_REM_W-1:0]     den_reg;
    logic [txf_pkg::GAIN_W-1:0]        quot_reg;
    logic [txf_pkg::GAIN_W-1:0]        gain_reg;

    logic                              first;
    logic [txf_pkg::DIV_REM_W-1:0]     trial;
    logic                              ge;
    logic [txf_pkg::DIV_REM_W-1:0]     rem_next;
    logic [txf_pkg::GAIN_W-1:0]        quot_next;

    // one trial subtract per step; the first step tests the unshifted fill
    always_comb begin
        first     = (cnt_reg == txf_pkg::DIV_CNT_W'(txf_pkg::DIV_STEPS));
        trial     = first ? rem_reg : {rem_reg[txf_pkg::DIV_REM_W-2:0], 1'b0};
        ge        = (trial >= den_reg);
        rem_next  = ge ? (trial - den_reg) : trial;
        quot_next = {quot_reg[txf_pkg::GAIN_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            gain_reg <= '0;
        end else if (start) begin
            if (den == '0) begin
                // zero peak gives zero gain at once
                gain_reg <= '0;
                busy_reg <= 1'b0;
            end else begin
                busy_reg <= 1'b1;
                cnt_reg  <= txf_pkg::DIV_CNT_W'(txf_pkg::DIV_STEPS);
            end
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == txf_pkg::DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
                gain_reg <= (quot_next > txf_pkg::GAIN_ONE) ? txf_pkg::GAIN_ONE : quot_next;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= {1'b0, num};
            den_reg  <= {1'b0, den};
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign busy = busy_reg;
    assign gain = gain_reg;

endmodule
`default_nettype wire

FILE: rtl/txf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txf_dp: crossfader datapath
// Input capture, time compares, tail store with fill and pointer, gain
// divider, mix multipliers with rounding and saturation, output register.
// ----------------------------------------------------------------------------
module txf_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [txf_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  wire logic                              s_tuser,
    input  wire logic                              cfg_wr_en,
    input  wire logic [txf_pkg::OVL_W-1:0]         cfg_wr_data,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic [txf_pkg::OUT_TDATA_W-1:0]        m_tdata,
    output logic                                   m_tuser,
    input  wire txf_pkg::txf_cmd_t                 cmd,
    output txf_pkg::txf_stat_t                     stat
);

    // configuration
    logic [txf_pkg::OVL_W-1:0]              overlap_reg;

    // captured item
    logic                                   start_reg;
    logic signed [txf_pkg::SAMPLE_BITS-1:0] sample_reg;
    logic [txf_pkg::MS_W-1:0]               dur_reg;
    logic signed [txf_pkg::REM_W-1:0]       rem_reg;
    logic                                   acc_reg;
    logic                                   rate_reg;
    logic                                   diff_reg;

    // tail store and its bookkeeping
    logic [txf_pkg::SAMPLE_BITS-1:0]        tail_mem [txf_pkg::TAIL_DEPTH];
    logic [txf_pkg::SAMPLE_BITS-1:0]        rd_data_reg;
    logic [txf_pkg::FILL_W-1:0]             fill_reg;
    logic [txf_pkg::FILL_W-1:0]             peak_reg;
    logic [txf_pkg::ADDR_W-1:0]             rp_reg;
    logic [txf_pkg::FILL_W-1:0]             fill_inc;
    logic [txf_pkg::FILL_W-1:0]             wr_sum;
    logic [txf_pkg::ADDR_W-1:0]             wr_addr;

    // mix pipeline
    logic [txf_pkg::GAIN_W-1:0]             gain;
    logic                                   div_busy;
    logic [txf_pkg::GAIN_W-1:0]             inv_gain;
    logic signed [txf_pkg::PROD_W-1:0]      p1_reg;
    logic signed [txf_pkg::PROD_W-1:0]      p2_reg;
    logic signed [txf_pkg::ACC_W-1:0]       acc_sum_reg;
    logic signed [txf_pkg::QUOT_W-1:0]      quot;
    logic signed [txf_pkg::SAMPLE_BITS-1:0] result_reg;

    // output register
    logic                                   m_tvalid_reg;
    logic [txf_pkg::SAMPLE_BITS-1:0]        out_sample_reg;
    logic                                   out_req_reg;

    // time compares
    logic [txf_pkg::OVG_W-1:0]              ov_guard;

    localparam logic signed [txf_pkg::QUOT_W-1:0] SMAX =
        txf_pkg::QUOT_W'((64'sd1 <<< (txf_pkg::SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [txf_pkg::QUOT_W-1:0] SMIN = -SMAX - 2'sd1;
    localparam logic signed [txf_pkg::ACC_W-1:0]  HALF =
        txf_pkg::ACC_W'(1 << (txf_pkg::GAIN_FRAC - 1));

    // overlap register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overlap_reg <= txf_pkg::OVERLAP_RESET;
        end else if (cfg_wr_en) begin
            overlap_reg <= cfg_wr_data;
        end
    end

    // capture one transfer, remaining time worked out on the way in
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            start_reg  <= s_tuser;
            sample_reg <= s_tdata[txf_pkg::IN_SAMPLE_LO +: txf_pkg::SAMPLE_BITS];
            dur_reg    <= s_tdata[txf_pkg::IN_DUR_LO +: txf_pkg::MS_W];
            rem_reg    <= $signed({1'b0, s_tdata[txf_pkg::IN_DUR_LO +: txf_pkg::MS_W]})
                        - $signed({1'b0, s_tdata[txf_pkg::IN_EL_LO +: txf_pkg::MS_W]});
            acc_reg    <= s_tdata[txf_pkg::IN_ACC_BIT];
            rate_reg   <= s_tdata[txf_pkg::IN_RATE_BIT];
            diff_reg   <= s_tdata[txf_pkg::IN_DIFF_BIT];
        end
    end

    assign ov_guard = txf_pkg::OVG_W'(overlap_reg) + txf_pkg::GUARD_MS;

    // status for mode decisions
    always_comb begin
        stat.blk_start = start_reg;
        stat.near_end  = (dur_reg > txf_pkg::MS_W'(ov_guard))
                      && (rem_reg < $signed(txf_pkg::REM_W'(ov_guard)));
        stat.absorb_ok = (dur_reg != '0)
                      && (rem_reg < $signed(txf_pkg::REM_W'(overlap_reg)));
        stat.next_acc  = acc_reg;
        stat.skip_next = rate_reg && diff_reg;
        stat.fill_nz   = (fill_reg != '0);
        stat.fill_full = fill_reg[txf_pkg::FILL_W-1];
        stat.div_busy  = div_busy;
        stat.out_free  = !m_tvalid_reg || m_tready;
    end

    // write address: oldest entry plus fill, wrapping at the store depth
    assign fill_inc = fill_reg + 1'b1;
    assign wr_sum   = txf_pkg::FILL_W'(rp_reg) + fill_reg;
    assign wr_addr  = wr_sum[txf_pkg::ADDR_W-1:0];

    // fill, peak and read pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            peak_reg <= '0;
            rp_reg   <= '0;
        end else if (cmd.absorb) begin
            fill_reg <= fill_inc;
            if (fill_inc > peak_reg) begin
                peak_reg <= fill_inc;
            end
        end else if (cmd.consume) begin
            fill_reg <= fill_reg - 1'b1;
            rp_reg   <= rp_reg + 1'b1;
        end
    end

    // tail store write port
    always_ff @(posedge aclk) begin
        if (cmd.absorb) begin
            tail_mem[wr_addr] <= sample_reg;
        end
    end

    // tail store read port
    always_ff @(posedge aclk) begin
        if (cmd.consume) begin
            rd_data_reg <= tail_mem[rp_reg];
        end
    end

    // gain latched at the start of a mix block
    txf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (fill_reg),
        .den     (peak_reg),
        .busy    (div_busy),
        .gain    (gain)
    );

    assign inv_gain = txf_pkg::GAIN_ONE - gain;
    assign quot     = acc_sum_reg[txf_pkg::ACC_W-1:txf_pkg::GAIN_FRAC];

    // mix: one product per cycle, round half up, floor shift, saturate
    always_ff @(posedge aclk) begin
        if (cmd.mul_a) begin
            p1_reg <= txf_pkg::PROD_W'(sample_reg) * $signed({1'b0, inv_gain});
        end
        if (cmd.mul_b) begin
            p2_reg <= txf_pkg::PROD_W'($signed(rd_data_reg)) * $signed({1'b0, gain});
        end
        if (cmd.sum) begin
            acc_sum_reg <= txf_pkg::ACC_W'(p1_reg) + txf_pkg::ACC_W'(p2_reg) + HALF;
        end
        if (cmd.sat) begin
            if (quot > SMAX) begin
                result_reg <= txf_pkg::SAMPLE_BITS'(SMAX);
            end else if (quot < SMIN) begin
                result_reg <= txf_pkg::SAMPLE_BITS'(SMIN);
            end else begin
                result_reg <= txf_pkg::SAMPLE_BITS'(quot);
            end
        end else if (cmd.pass) begin
            result_reg <= sample_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_sample_reg <= result_reg;
            out_req_reg    <= cmd.req;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = txf_pkg::OUT_TDATA_W'(out_sample_reg);
    assign m_tuser  = out_req_reg;

    // checks on store bookkeeping and the output register
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= txf_pkg::FILL_W'(txf_pkg::TAIL_DEPTH))
        else $error("fill beyond store depth");

    a_fill_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= peak_reg)
        else $error("fill above peak");

    a_one_port_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.absorb && cmd.consume))
        else $error("absorb and consume together");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten");

endmodule
`default_nettype wire

FILE: rtl/txf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txf_ctrl: crossfader controller
// Holds the track mode and the per-block action, and sequences each item
// through decision, divider wait, store access, mix and output load.
// ----------------------------------------------------------------------------
module txf_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire txf_pkg::txf_stat_t    stat,
    output txf_pkg::txf_cmd_t          cmd
);

    typedef enum logic [2:0] {
        MODE_WAITING    = 3'd0,
        MODE_CHECKING   = 3'd1,
        MODE_PREPARING  = 3'd2,
        MODE_PROCESSING = 3'd3,
        MODE_SKIPPING   = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_ACT,
        ST_MUL,
        ST_SUM,
        ST_SAT,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    mode_t  blk_reg, blk_next;
    logic   req_reg, req_next;

    // next state, mode decisions and commands
    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        blk_next   = blk_reg;
        req_next   = req_reg;
        cmd        = '0;
        cmd.req    = req_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                req_next   = 1'b0;
                state_next = ST_ACT;
                if (stat.blk_start) begin
                    blk_next = MODE_WAITING;
                    case (mode_reg)
                        MODE_WAITING: begin
                            if (stat.near_end) begin
                                req_next  = 1'b1;
                                mode_next = MODE_CHECKING;
                            end
                        end
                        MODE_CHECKING: begin
                            if (stat.next_acc) begin
                                mode_next = stat.skip_next ? MODE_SKIPPING : MODE_PREPARING;
                            end
                        end
                        MODE_PREPARING: begin
                            if (stat.absorb_ok) begin
                                blk_next = MODE_PREPARING;
                            end else if (stat.fill_nz) begin
                                mode_next = MODE_PROCESSING;
                            end
                        end
                        MODE_PROCESSING: begin
                            if (stat.fill_nz) begin
                                blk_next      = MODE_PROCESSING;
                                cmd.div_start = 1'b1;
                                state_next    = ST_DIV;
                            end else begin
                                mode_next = MODE_WAITING;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (!stat.div_busy) begin
                    state_next = ST_ACT;
                end
            end
            ST_ACT: begin
                if (blk_reg == MODE_PREPARING && !stat.fill_full) begin
                    // absorbed items give no result
                    cmd.absorb = 1'b1;
                    state_next = ST_IDLE;
                end else if (blk_reg == MODE_PROCESSING && stat.fill_nz) begin
                    cmd.consume = 1'b1;
                    cmd.mul_a   = 1'b1;
                    state_next  = ST_MUL;
                end else begin
                    cmd.pass   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_MUL: begin
                cmd.mul_b  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT: begin
                cmd.sat    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, mode and request flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_WAITING;
            blk_reg   <= MODE_WAITING;
            req_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            blk_reg   <= blk_next;
            req_reg   <= req_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // sequencing checks
    a_div_only_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> (blk_reg == MODE_PROCESSING && mode_reg == MODE_PROCESSING))
        else $error("division outside a mix block");

    a_absorb_in_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.absorb |-> (mode_reg == MODE_PREPARING))
        else $error("absorb outside preparing mode");

    a_req_from_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(req_reg) |-> (mode_reg == MODE_CHECKING && $past(mode_reg) == MODE_WAITING))
        else $error("request without wait to check step");

endmodule
`default_nettype wire

FILE: rtl/track_tail_crossfader.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// track_tail_crossfader: tail store and crossfade into the next track
// Requests the next track near the end of the current one, stores the
// track's tail and mixes it into the new track with a per-block gain.
//
// channel   direction  payload
// s_*       in         tuser: block_start; tdata: sample, duration_ms,
//                      elapsed_ms, next_accepted, next_rate_known,
//                      next_format_differs
// m_*       out        tuser: next_track_request; tdata: sample_out
// cfg_*     in         overlap_ms, written when cfg_wr_en is high
//
// An item is absorbed into the store, passed or mixed; the first item of a
// mix block also waits for the bit-serial gain divider. The mix path is set
// by its two multiplies and the registered store read. The store is not
// cleared: only written entries are read. Reset clears modes, fill, pointer,
// peak and gain. A stalled output holds the next finished item in the
// controller until the register frees.
// ----------------------------------------------------------------------------
module track_tail_crossfader (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // sample, duration_ms, elapsed_ms, next_accepted, next_rate_known,
    // next_format_differs, zero fill
    input  wire logic [txf_pkg::IN_TDATA_W-1:0]    s_tdata,
    // block_start
    input  wire logic                              s_tuser,
    // result channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // sample_out
    output logic [txf_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // next_track_request
    output logic                                   m_tuser,
    // overlap register
    input  wire logic                              cfg_wr_en,
    input  wire logic [txf_pkg::OVL_W-1:0]         cfg_wr_data
);

    txf_pkg::txf_cmd_t  cmd;
    txf_pkg::txf_stat_t stat;

    // sequencer
    txf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, divider and mix
    txf_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
`default_nettype wire

FILE: sim/track_tail_crossfader_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_tail_crossfader_tb: self-checking bench for the tail crossfader
// Feeds track-change scenarios (request, check, tail capture, fade, skip)
// with random content and random stalls on both stream sides. Each accepted
// sample is run through a local copy of the crossfade behavior, and every
// output transfer is compared against the oldest predicted sample.
// ----------------------------------------------------------------------------
module track_tail_crossfader_tb;

    localparam int ITEM_GOAL     = 1900;
    localparam int CALM_ITEMS    = 250;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 600000;

    typedef enum logic [2:0] {
        XF_WAIT,
        XF_CHECK,
        XF_PREP,
        XF_FADE,
        XF_SKIP
    } xf_mode_t;

    typedef struct {
        logic                                   blk;
        logic signed [txf_pkg::SAMPLE_BITS-1:0] smp;
        logic [txf_pkg::MS_W-1:0]               dur;
        logic [txf_pkg::MS_W-1:0]               el;
        logic                                   acc;
        logic                                   rate;
        logic                                   diff;
    } track_sample_t;

    typedef struct {
        logic [txf_pkg::SAMPLE_BITS-1:0] smp;
        logic                            req;
    } faded_sample_t;

    // dut ports
    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [txf_pkg::IN_TDATA_W-1:0]  s_tdata     = '0;
    logic                            s_tuser     = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [txf_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tuser;
    logic                            cfg_wr_en   = 1'b0;
    logic [txf_pkg::OVL_W-1:0]       cfg_wr_data = '0;

    // stimulus and scoreboard storage
    track_sample_t sample_feed [$];
    faded_sample_t due_samples [$];
    int            items_sent  = 0;
    int            fail_count  = 0;
    int            cycle_count = 0;
    int unsigned   plan_ovl    = txf_pkg::OVERLAP_RESET;
    logic          in_fire     = 1'b0;
    logic          idle_on     = 1'b1;
    logic          calm        = 1'b0;
    int            send_gap    = 0;
    int            stall_left  = 0;
    track_sample_t drive_item;
    track_sample_t seen_item;
    faded_sample_t want;
    logic [txf_pkg::IN_TDATA_W-1:0] feed_bits;

    // local copy of the crossfader state
    xf_mode_t                               mode_q  = XF_WAIT;
    xf_mode_t                               blk_act = XF_WAIT;
    logic [txf_pkg::FILL_W-1:0]             fill_q  = '0;
    logic [txf_pkg::ADDR_W-1:0]             rd_ptr  = '0;
    logic [txf_pkg::FILL_W-1:0]             peak_q  = '0;
    logic [txf_pkg::GAIN_W-1:0]             gain_q  = '0;
    logic [txf_pkg::OVL_W-1:0]              ovl_q   = txf_pkg::OVERLAP_RESET;
    logic signed [txf_pkg::SAMPLE_BITS-1:0] tail_mem [int unsigned];

    track_tail_crossfader i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // block decision, tail capture and mix for one accepted sample
    function automatic void step_crossfade(input track_sample_t item);
        longint        remain;
        longint        lim;
        longint        g;
        longint        sum;
        longint        mixed;
        longint        smax;
        faded_sample_t res;
        remain  = longint'(item.dur) - longint'(item.el);
        lim     = longint'(ovl_q) + longint'(txf_pkg::GUARD_MS);
        smax    = (longint'(1) << (txf_pkg::SAMPLE_BITS - 1)) - 1;
        res.smp = item.smp;
        res.req = 1'b0;
        if (item.blk) begin
            blk_act = XF_WAIT;
            case (mode_q)
                XF_WAIT: begin
                    if (longint'(item.dur) > lim && remain < lim) begin
                        res.req = 1'b1;
                        mode_q  = XF_CHECK;
                    end
                end
                XF_CHECK: begin
                    if (item.acc)
                        mode_q = (item.rate && item.diff) ? XF_SKIP : XF_PREP;
                end
                XF_PREP: begin
                    if (item.dur != 0 && remain < longint'(ovl_q))
                        blk_act = XF_PREP;
                    else if (fill_q != 0)
                        mode_q = XF_FADE;
                end
                XF_FADE: begin
                    if (fill_q != 0) begin
                        g = (peak_q != 0) ?
                            (longint'(fill_q) << txf_pkg::GAIN_FRAC) / longint'(peak_q)
                            : 0;
                        if (g > longint'(txf_pkg::GAIN_ONE))
                            g = longint'(txf_pkg::GAIN_ONE);
                        gain_q  = txf_pkg::GAIN_W'(g);
                        blk_act = XF_FADE;
                    end else begin
                        mode_q = XF_WAIT;
                    end
                end
                default: ;
            endcase
        end
        // tail capture: no output while the store has room
        if (blk_act == XF_PREP && fill_q < txf_pkg::TAIL_DEPTH) begin
            tail_mem[(longint'(rd_ptr) + longint'(fill_q)) % txf_pkg::TAIL_DEPTH] =
                item.smp;
            fill_q = fill_q + 1'b1;
            if (fill_q > peak_q)
                peak_q = fill_q;
            return;
        end
        // fade the stored tail into the new track, rounded half up
        if (blk_act == XF_FADE && fill_q != 0) begin
            g     = longint'(gain_q);
            sum   = longint'(item.smp) * (longint'(txf_pkg::GAIN_ONE) - g)
                  + longint'(tail_mem[rd_ptr]) * g + (longint'(txf_pkg::GAIN_ONE) >>> 1);
            mixed = sum >>> txf_pkg::GAIN_FRAC;
            if (mixed > smax)
                mixed = smax;
            if (mixed < -smax - 1)
                mixed = -smax - 1;
            res.smp = txf_pkg::SAMPLE_BITS'(mixed);
            rd_ptr  = (rd_ptr == txf_pkg::ADDR_W'(txf_pkg::TAIL_DEPTH - 1)) ?
                      '0 : rd_ptr + 1'b1;
            fill_q  = fill_q - 1'b1;
        end
        due_samples.push_back(res);
    endfunction

    // sample values weighted toward the full-scale ends and minus one
    function automatic logic [txf_pkg::SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return {1'b0, {(txf_pkg::SAMPLE_BITS - 1){1'b1}}};
            1:       return {1'b1, {(txf_pkg::SAMPLE_BITS - 1){1'b0}}};
            2:       return {txf_pkg::SAMPLE_BITS{1'b1}};
            default: return txf_pkg::SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic push_item(input logic blk, input logic [txf_pkg::SAMPLE_BITS-1:0] smp,
                             input logic [txf_pkg::MS_W-1:0] dur,
                             input logic [txf_pkg::MS_W-1:0] el,
                             input logic acc, input logic rate, input logic diff);
        track_sample_t item;
        item.blk  = blk;
        item.smp  = smp;
        item.dur  = dur;
        item.el   = el;
        item.acc  = acc;
        item.rate = rate;
        item.diff = diff;
        sample_feed.push_back(item);
        items_sent++;
    endtask

    // one buffer: the header carries the decision fields, the rest is random
    task automatic push_block(input logic [txf_pkg::MS_W-1:0] dur,
                              input logic [txf_pkg::MS_W-1:0] el,
                              input logic acc, input logic rate, input logic diff,
                              input int len);
        push_item(1'b1, rand_sample(), dur, el, acc, rate, diff);
        repeat (len - 1)
            push_item(1'b0, rand_sample(), $urandom, $urandom, 1'($urandom),
                      1'($urandom), 1'($urandom));
    endtask

    // times that keep the idle state from requesting the next track
    task automatic far_from_end(output logic [txf_pkg::MS_W-1:0] dur,
                                output logic [txf_pkg::MS_W-1:0] el);
        int unsigned lim;
        lim = plan_ovl + txf_pkg::GUARD_MS;
        if ($urandom_range(0, 3) == 0) begin
            dur = $urandom_range(0, lim);
            el  = $urandom;
        end else begin
            dur = $urandom_range(lim, 32'hFFFF_FFFF);
            el  = $urandom_range(0, dur - lim);
        end
    endtask

    // times that make the idle state request the next track
    task automatic near_track_end(output logic [txf_pkg::MS_W-1:0] dur,
                                  output logic [txf_pkg::MS_W-1:0] el);
        int unsigned lim;
        lim = plan_ovl + txf_pkg::GUARD_MS;
        dur = $urandom_range(lim + 1, 32'hFFFF_FFFF);
        if ($urandom_range(0, 3) == 0 && dur != 32'hFFFF_FFFF)
            el = $urandom_range(dur + 1, 32'hFFFF_FFFF);
        else
            el = dur - $urandom_range(0, lim - 1);
    endtask

    // times inside the overlap window: the block is captured
    task automatic in_overlap(output logic [txf_pkg::MS_W-1:0] dur,
                              output logic [txf_pkg::MS_W-1:0] el);
        if (plan_ovl > 0 && $urandom_range(0, 3) != 0) begin
            dur = $urandom_range(plan_ovl, 32'hFFFF_FFFF);
            el  = dur - $urandom_range(0, plan_ovl - 1);
        end else begin
            dur = $urandom_range(1, 32'hFFFF_FFFE);
            el  = $urandom_range(dur + 1, 32'hFFFF_FFFF);
        end
    endtask

    // times outside the overlap window, or unknown duration
    task automatic out_of_overlap(output logic [txf_pkg::MS_W-1:0] dur,
                                  output logic [txf_pkg::MS_W-1:0] el);
        if ($urandom_range(0, 2) == 0) begin
            dur = '0;
            el  = $urandom;
        end else begin
            dur = $urandom_range(plan_ovl, 32'hFFFF_FFFF);
            el  = $urandom_range(0, dur - plan_ovl);
        end
    endtask

    // one track change: request, accept, then either skip or tail capture, fade and back to idle
    task automatic track_change(input int tail_max, input bit to_skip);
        logic [txf_pkg::MS_W-1:0] d;
        logic [txf_pkg::MS_W-1:0] e;
        logic                     r;
        logic                     f;
        bit                       armed;
        int                       fill;
        int                       used;
        int                       n;
        int                       target;
        armed = 0;
        // idle buffers, some with random times that may fire the request
        repeat ($urandom_range(0, 3)) begin
            if (!armed) begin
                if ($urandom_range(0, 1) == 1) begin
                    d     = $urandom;
                    e     = $urandom;
                    armed = (longint'(d) > longint'(plan_ovl + txf_pkg::GUARD_MS)) &&
                            (longint'(d) - longint'(e) <
                             longint'(plan_ovl + txf_pkg::GUARD_MS));
                end else begin
                    far_from_end(d, e);
                end
                push_block(d, e, 1'($urandom), 1'($urandom), 1'($urandom),
                           $urandom_range(1, 6));
            end
        end
        if (!armed) begin
            near_track_end(d, e);
            push_block(d, e, 1'($urandom), 1'($urandom), 1'($urandom),
                       $urandom_range(1, 6));
        end
        // next track not yet accepted
        repeat ($urandom_range(0, 2))
            push_block($urandom, $urandom, 1'b0, 1'($urandom), 1'($urandom),
                       $urandom_range(1, 5));
        if (to_skip) begin
            push_block($urandom, $urandom, 1'b1, 1'b1, 1'b1, $urandom_range(1, 5));
            repeat (8)
                push_block($urandom, $urandom, 1'($urandom), 1'($urandom),
                           1'($urandom), $urandom_range(1, 8));
            return;
        end
        case ($urandom_range(0, 2))
            0:       begin r = 1'b0; f = 1'b0; end
            1:       begin r = 1'b0; f = 1'b1; end
            default: begin r = 1'b1; f = 1'b0; end
        endcase
        push_block($urandom, $urandom, 1'b1, r, f, $urandom_range(1, 5));
        // an empty store outside the window stays in capture
        if ($urandom_range(0, 3) == 0) begin
            out_of_overlap(d, e);
            push_block(d, e, 1'($urandom), 1'($urandom), 1'($urandom),
                       $urandom_range(1, 4));
        end
        fill   = 0;
        target = $urandom_range(1, tail_max);
        while (fill < target) begin
            n = $urandom_range(1, 8);
            in_overlap(d, e);
            push_block(d, e, 1'($urandom), 1'($urandom), 1'($urandom), n);
            fill += n;
        end
        // leaving the window starts the fade on the following buffer
        out_of_overlap(d, e);
        push_block(d, e, 1'($urandom), 1'($urandom), 1'($urandom), $urandom_range(1, 4));
        used = 0;
        while (used < fill) begin
            n = $urandom_range(1, 10);
            push_block($urandom, $urandom, 1'($urandom), 1'($urandom), 1'($urandom), n);
            used += n;
        end
        // empty store at buffer start: back to idle
        push_block($urandom, $urandom, 1'($urandom), 1'($urandom), 1'($urandom),
                   $urandom_range(1, 4));
    endtask

    // wait until all samples are out and the datapath has gone quiet
    task automatic settle();
        while (sample_feed.size() != 0 || s_tvalid || due_samples.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_overlap(input int unsigned value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= txf_pkg::OVL_W'(value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        plan_ovl = value;
    endtask

    // input driver: one sample per transfer, random gaps in bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (sample_feed.size() != 0) begin
                drive_item = sample_feed.pop_front();
                feed_bits  = '0;
                feed_bits[txf_pkg::IN_SAMPLE_LO +: txf_pkg::SAMPLE_BITS] = drive_item.smp;
                feed_bits[txf_pkg::IN_DUR_LO +: txf_pkg::MS_W]           = drive_item.dur;
                feed_bits[txf_pkg::IN_EL_LO +: txf_pkg::MS_W]            = drive_item.el;
                feed_bits[txf_pkg::IN_ACC_BIT]                           = drive_item.acc;
                feed_bits[txf_pkg::IN_RATE_BIT]                          = drive_item.rate;
                feed_bits[txf_pkg::IN_DIFF_BIT]                          = drive_item.diff;
                s_tdata  <= feed_bits;
                s_tuser  <= drive_item.blk;
                s_tvalid <= 1'b1;
                if (!calm && idle_on && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 7);
                if ($urandom_range(0, 49) == 0)
                    idle_on <= !idle_on;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output backpressure in random bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && idle_on && $urandom_range(0, 6) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: check output transfers, predict from input transfers
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (due_samples.size() == 0) begin
                    $display("%0t unexpected output: actual sample %h request %b",
                             $time, m_tdata[txf_pkg::SAMPLE_BITS-1:0], m_tuser);
                    fail_count++;
                end else begin
                    want = due_samples.pop_front();
                    if (m_tdata[txf_pkg::SAMPLE_BITS-1:0] !== want.smp) begin
                        $display("%0t sample_out mismatch: expected %h actual %h",
                                 $time, want.smp, m_tdata[txf_pkg::SAMPLE_BITS-1:0]);
                        fail_count++;
                    end
                    if (m_tuser !== want.req) begin
                        $display("%0t next_track_request mismatch: expected %b actual %b",
                                 $time, want.req, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                seen_item.blk  = s_tuser;
                seen_item.smp  = s_tdata[txf_pkg::IN_SAMPLE_LO +: txf_pkg::SAMPLE_BITS];
                seen_item.dur  = s_tdata[txf_pkg::IN_DUR_LO +: txf_pkg::MS_W];
                seen_item.el   = s_tdata[txf_pkg::IN_EL_LO +: txf_pkg::MS_W];
                seen_item.acc  = s_tdata[txf_pkg::IN_ACC_BIT];
                seen_item.rate = s_tdata[txf_pkg::IN_RATE_BIT];
                seen_item.diff = s_tdata[txf_pkg::IN_DIFF_BIT];
                step_crossfade(seen_item);
            end
            if (cfg_wr_en)
                ovl_q = cfg_wr_data;
        end
        in_fire <= s_tvalid && s_tready;
    end

    // run time guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        int phase;
        int unsigned value;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // samples before any buffer start pass through
        push_item(1'b0, 24'h7F_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1, 1'b1);
        push_item(1'b0, 24'h80_0000, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        // idle: unknown duration, far from end, guard edge, short track
        push_item(1'b1, 24'h00_0000, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0);
        push_item(1'b1, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1, 1'b1);
        push_item(1'b1, 24'h00_0001, 32'd8000, 32'd7999, 1'b0, 1'b0, 1'b0);
        push_item(1'b1, 24'h12_3456, 32'd1000, 32'd5000, 1'b0, 1'b0, 1'b0);
        // elapsed past duration: request the next track
        push_item(1'b1, 24'h7F_FFFF, 32'd8001, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        push_item(1'b0, rand_sample(), $urandom, $urandom, 1'b1, 1'b1, 1'b1);
        // not accepted yet, then accepted with a matching format
        push_item(1'b1, rand_sample(), $urandom, $urandom, 1'b0, 1'b1, 1'b1);
        push_item(1'b1, rand_sample(), $urandom, $urandom, 1'b1, 1'b1, 1'b0);
        // empty store outside the window, then capture four samples
        push_item(1'b1, rand_sample(), 32'h0, 32'h0, 1'b0, 1'b0, 1'b0);
        push_item(1'b1, 24'h7F_FFFF, 32'd100000, 32'd94001, 1'b0, 1'b0, 1'b0);
        push_item(1'b0, 24'h80_0000, $urandom, $urandom, 1'b0, 1'b0, 1'b0);
        push_item(1'b0, 24'h00_0000, $urandom, $urandom, 1'b0, 1'b0, 1'b0);
        push_item(1'b0, 24'h7F_FFFF, $urandom, $urandom, 1'b0, 1'b0, 1'b0);
        // window edge: fade starts on the next buffer
        push_item(1'b1, rand_sample(), 32'd100000, 32'd94000, 1'b0, 1'b0, 1'b0);
        // full gain, then half gain with an empty store at the tail
        push_item(1'b1, 24'h00_0000, $urandom, $urandom, 1'b0, 1'b0, 1'b0);
        push_item(1'b0, 24'h7F_FFFF, $urandom, $urandom, 1'b0, 1'b0, 1'b0);
        push_item(1'b1, 24'h7F_FFFF, $urandom, $urandom, 1'b0, 1'b0, 1'b0);
        push_item(1'b0, 24'h80_0000, $urandom, $urandom, 1'b0, 1'b0, 1'b0);
        push_item(1'b0, 24'h80_0000, $urandom, $urandom, 1'b0, 1'b0, 1'b0);
        // store empty at buffer start: back to idle
        push_item(1'b1, rand_sample(), $urandom, $urandom, 1'b0, 1'b0, 1'b0);
        push_item(1'b0, rand_sample(), $urandom, $urandom, 1'b0, 1'b0, 1'b0);

        // random track changes under several overlap settings
        phase = 0;
        while (items_sent < ITEM_GOAL - CALM_ITEMS) begin
            settle();
            case (phase)
                0:       value = 0;
                1:       value = 60000;
                default: value = $urandom_range(0, 60000);
            endcase
            write_overlap(value);
            repeat (4)
                track_change(($urandom_range(0, 4) == 0) ? 300 : 40, 1'b0);
            phase++;
        end

        // last part without stalls, ending in the skip state
        settle();
        calm = 1'b1;
        write_overlap(txf_pkg::OVERLAP_RESET);
        while (items_sent < ITEM_GOAL)
            track_change(40, 1'b0);
        track_change(20, 1'b1);

        settle();
        if (fail_count == 0 && due_samples.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/txf_pkg.sv
rtl/txf_div.sv
rtl/txf_dp.sv
rtl/txf_ctrl.sv
rtl/track_tail_crossfader.sv
sim/track_tail_crossfader_tb.sv
